[hw/rtl/pses_pkg.sv]
package pses_pkg;

  // Format of the samples and of the run counter.
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int FRAC_BITS   = 8;
  localparam int NORM_FRAC   = 16;

  // Derived widths.
  localparam int SUM_BITS     = COUNT_BITS + SAMPLE_BITS;
  localparam int SQ_BITS      = COUNT_BITS + 2 * SAMPLE_BITS;
  localparam int DVD_BITS     = SQ_BITS + 2 * NORM_FRAC;
  localparam int DVS_BITS     = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;
  localparam int ROOT_IN_BITS = 2 * SAMPLE_BITS + 2 * NORM_FRAC;
  localparam int ROOT_BITS    = ROOT_IN_BITS / 2;
  localparam int SQRT_STEPS   = ROOT_BITS;
  localparam int STEP_W       = $clog2(DVD_BITS + 1);

  localparam logic [23:0] NORM_MAX = 24'hFFFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DLOAD,
    ST_DSTEP,
    ST_DSTORE,
    ST_SQSTEP,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_MEAN_A,
    OP_MEAN_B,
    OP_MSQ,
    OP_NRM_R,
    OP_NRM_L
  } op_e;

  typedef struct packed {
    logic acc;
    logic div_load;
    logic div_step;
    logic div_store;
    logic sqrt_step;
    logic out_load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

[hw/rtl/pses_ctrl.sv]
module pses_ctrl import pses_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  input  logic s_last_i,
  output logic s_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  op_e op_q, op_d;
  logic [STEP_W-1:0] step_q, step_d;

  // State, operation and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_MEAN_A;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      step_q  <= step_d;
    end
  end

  // Next state: a last word runs the divisions and the root in a fixed order.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i && s_last_i) begin
          state_d = ST_DLOAD;
          op_d    = OP_MEAN_A;
        end
      end
      ST_DLOAD: begin
        state_d = ST_DSTEP;
        step_d  = '0;
      end
      ST_DSTEP: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DVD_BITS - 1)) state_d = ST_DSTORE;
      end
      ST_DSTORE: begin
        unique case (op_q)
          OP_MEAN_A: begin
            op_d    = OP_MEAN_B;
            state_d = ST_DLOAD;
          end
          OP_MEAN_B: begin
            op_d    = OP_MSQ;
            state_d = ST_DLOAD;
          end
          OP_MSQ: begin
            state_d = ST_SQSTEP;
            step_d  = '0;
          end
          OP_NRM_R: begin
            op_d    = OP_NRM_L;
            state_d = ST_DLOAD;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_SQSTEP: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          state_d = ST_DLOAD;
          op_d    = OP_NRM_R;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    s_ready_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        cmd_o.acc = s_valid_i;
      end
      ST_DLOAD:  cmd_o.div_load  = 1'b1;
      ST_DSTEP:  cmd_o.div_step  = 1'b1;
      ST_DSTORE: cmd_o.div_store = 1'b1;
      ST_SQSTEP: cmd_o.sqrt_step = 1'b1;
      ST_FIN:    cmd_o.out_load  = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

[hw/rtl/pses_dp.sv]
module pses_dp import pses_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output sts_t         sts_o,
  input  logic [15:0]  sample_a_i,
  input  logic [15:0]  sample_b_i,
  output logic         m_valid_o,
  input  logic         m_ready_i,
  output logic [199:0] m_data_o,
  output logic         m_user_o
);

  // Run accumulators.
  logic [COUNT_BITS-1:0]         count_q;
  logic signed [SUM_BITS-1:0]    sum_a_q, sum_b_q;
  logic [SQ_BITS-1:0]            sq_q;
  logic [SAMPLE_BITS-1:0]        peak_q;
  logic signed [SAMPLE_BITS-1:0] low_a_q, high_a_q, low_b_q, high_b_q;

  logic signed [SAMPLE_BITS-1:0] a, b;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          ad_full;
  logic [SAMPLE_BITS-1:0]        ad;
  logic [2*SAMPLE_BITS-1:0]      ad_sq;

  assign a       = $signed(sample_a_i[SAMPLE_BITS-1:0]);
  assign b       = $signed(sample_b_i[SAMPLE_BITS-1:0]);
  assign diff    = (SAMPLE_BITS+1)'(a) - (SAMPLE_BITS+1)'(b);
  assign ad_full = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
  assign ad      = ad_full[SAMPLE_BITS-1:0];
  assign ad_sq   = ad * ad;

  // Accumulate a word until the counter is full; the result clears the run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_a_q  <= '0;
      sum_b_q  <= '0;
      sq_q     <= '0;
      peak_q   <= '0;
      low_a_q  <= '0;
      high_a_q <= '0;
      low_b_q  <= '0;
      high_b_q <= '0;
    end else if (cmd_i.out_load) begin
      count_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      sq_q    <= '0;
      peak_q  <= '0;
    end else if (cmd_i.acc && (count_q != '1)) begin
      if (count_q == '0) begin
        low_a_q  <= a;
        high_a_q <= a;
        low_b_q  <= b;
        high_b_q <= b;
      end else begin
        if (a < low_a_q)  low_a_q  <= a;
        if (a > high_a_q) high_a_q <= a;
        if (b < low_b_q)  low_b_q  <= b;
        if (b > high_b_q) high_b_q <= b;
      end
      sum_a_q <= sum_a_q + SUM_BITS'(a);
      sum_b_q <= sum_b_q + SUM_BITS'(b);
      sq_q    <= sq_q + SQ_BITS'(ad_sq);
      if (ad > peak_q) peak_q <= ad;
      count_q <= count_q + 1'b1;
    end
  end

  // Operands of the shared divider.
  logic [SAMPLE_BITS-1:0] rng;
  logic                   rz;
  logic [SUM_BITS-1:0]    mag_a, mag_b;

  assign rng   = SAMPLE_BITS'(high_a_q - low_a_q);
  assign rz    = (rng == '0);
  assign mag_a = sum_a_q[SUM_BITS-1] ? SUM_BITS'(-sum_a_q) : SUM_BITS'(sum_a_q);
  assign mag_b = sum_b_q[SUM_BITS-1] ? SUM_BITS'(-sum_b_q) : SUM_BITS'(sum_b_q);

  // Restoring divider, one quotient bit per step.
  logic [DVD_BITS-1:0] dvd_q;
  logic [DVS_BITS-1:0] rem_q, dvsr_q;
  logic                neg_q;
  logic [DVS_BITS:0]   trial_sh, trial;
  logic                ge;

  assign trial_sh = {rem_q, dvd_q[DVD_BITS-1]};
  assign ge       = (trial_sh >= {1'b0, dvsr_q});
  assign trial    = trial_sh - {1'b0, dvsr_q};

  // Square root, two radicand bits per step.
  logic [ROOT_IN_BITS-1:0] sq_n_q, res_q, bit_q, res_bit;
  logic [ROOT_BITS-1:0]    root;
  logic [ROOT_BITS-1:0]    root_sh;

  assign res_bit = res_q + bit_q;
  assign root    = res_q[ROOT_BITS-1:0];
  assign root_sh = root >> (NORM_FRAC - FRAC_BITS);

  logic [23:0] mean_a_q, mean_b_q, nr_q, nl_q;
  logic [23:0] quo_lo, quo_sat;

  assign quo_lo  = dvd_q[23:0];
  assign quo_sat = (|dvd_q[DVD_BITS-1:24]) ? NORM_MAX : quo_lo;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      unique case (cmd_i.op)
        OP_MEAN_A: begin
          dvd_q  <= DVD_BITS'(mag_a) << FRAC_BITS;
          dvsr_q <= DVS_BITS'(count_q);
          neg_q  <= sum_a_q[SUM_BITS-1];
        end
        OP_MEAN_B: begin
          dvd_q  <= DVD_BITS'(mag_b) << FRAC_BITS;
          dvsr_q <= DVS_BITS'(count_q);
          neg_q  <= sum_b_q[SUM_BITS-1];
        end
        OP_MSQ: begin
          dvd_q  <= DVD_BITS'(sq_q) << (2 * NORM_FRAC);
          dvsr_q <= DVS_BITS'(count_q);
          neg_q  <= 1'b0;
        end
        OP_NRM_R: begin
          dvd_q  <= DVD_BITS'(root);
          dvsr_q <= DVS_BITS'(rng);
          neg_q  <= 1'b0;
        end
        default: begin
          dvd_q  <= DVD_BITS'(peak_q) << NORM_FRAC;
          dvsr_q <= DVS_BITS'(rng);
          neg_q  <= 1'b0;
        end
      endcase
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DVD_BITS-2:0], ge};
      rem_q <= ge ? trial[DVS_BITS-1:0] : trial_sh[DVS_BITS-1:0];
    end

    // Capture the quotient where the current operation sends it.
    if (cmd_i.div_store) begin
      unique case (cmd_i.op)
        OP_MEAN_A: mean_a_q <= neg_q ? 24'(-quo_lo) : quo_lo;
        OP_MEAN_B: mean_b_q <= neg_q ? 24'(-quo_lo) : quo_lo;
        OP_MSQ: begin
          sq_n_q <= dvd_q[ROOT_IN_BITS-1:0];
          res_q  <= '0;
          bit_q  <= ROOT_IN_BITS'(1) << (ROOT_IN_BITS - 2);
        end
        OP_NRM_R: nr_q <= quo_sat;
        default:  nl_q <= quo_sat;
      endcase
    end else if (cmd_i.sqrt_step) begin
      if (sq_n_q >= res_bit) begin
        sq_n_q <= sq_n_q - res_bit;
        res_q  <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Output register with its valid flag.
  logic         out_valid_q;
  logic [199:0] out_data_q;
  logic         out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {rz ? NORM_MAX : nl_q,
                     rz ? NORM_MAX : nr_q,
                     16'(peak_q),
                     root_sh[23:0],
                     mean_b_q,
                     mean_a_q,
                     16'(high_b_q),
                     16'(low_b_q),
                     16'(high_a_q),
                     16'(low_a_q)};
      out_user_q <= rz;
    end
  end

  assign sts_o.out_busy = out_valid_q && !m_ready_i;
  assign m_valid_o      = out_valid_q;
  assign m_data_o       = out_data_q;
  assign m_user_o       = out_user_q;

endmodule

[hw/rtl/paired_stream_error_statistics_unit.sv]
// Paired-stream error statistics. Each input word carries a pair of signed
// samples and a last flag; the pair is folded into exact running sums, a sum
// of squared differences, the peak absolute difference and the extremes of
// both streams. A word that is not last does not stall the input. A last word is
// accumulated too, and then the block runs five divisions on a shared
// restoring divider and a square root of SQRT_STEPS steps, during which
// s_axis_tready_o is low. The result word then goes to the output
// register, which holds it until taken; new words are accepted meanwhile.
// The counter saturates at 2^COUNT_BITS - 1 pairs; later pairs of that run
// are ignored. A zero range of A sets tuser and saturates both normalized
// values.
module paired_stream_error_statistics_unit import pses_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // sample_a [15:0], sample_b [31:16]
  input  logic [31:0]  s_axis_tdata_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // min_a, max_a, min_b, max_b, mean_a, mean_b, rmse, abs_error_max,
  // rmse_normalized, abs_error_max_normalized (lowest bit up)
  output logic [199:0] m_axis_tdata_o,
  // range_zero
  output logic         m_axis_tuser_o
);

  cmd_t cmd;
  sts_t sts;

  pses_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pses_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_a_i (s_axis_tdata_i[15:0]),
    .sample_b_i (s_axis_tdata_i[31:16]),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_o   (m_axis_tdata_o),
    .m_user_o   (m_axis_tuser_o)
  );

endmodule

[hw/rtl/pses_checker.sv]
module pses_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [31:0]  s_axis_tdata_i,
  input logic         s_axis_tlast_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [199:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  // A pending result word stays valid.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  // A pending result word keeps its data.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // A last word starts the computation, so the input stalls next cycle.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input accepted right after a last word");

  // A zero range saturates both normalized values.
  a_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (m_axis_tdata_o[175:152] == 24'hFFFFFF) && (m_axis_tdata_o[199:176] == 24'hFFFFFF))
    else $error("zero range without saturation");

  // The extremes of A are ordered.
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $signed(m_axis_tdata_o[15:0]) <= $signed(m_axis_tdata_o[31:16]))
    else $error("min_a above max_a");

endmodule

bind paired_stream_error_statistics_unit pses_checker u_pses_checker (.*);

[verif/paired_stream_error_statistics_unit_tb.sv]
module paired_stream_error_statistics_unit_tb;
  import pses_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 600;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  // sample_a [15:0], sample_b [31:16]
  logic [31:0]  s_axis_tdata_i;
  logic         s_axis_tlast_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  // min_a, max_a, min_b, max_b, mean_a, mean_b, rmse, abs_error_max,
  // rmse_normalized, abs_error_max_normalized (lowest bit up)
  logic [199:0] m_axis_tdata_o;
  // range_zero
  logic         m_axis_tuser_o;

  paired_stream_error_statistics_unit DUT (.*);

  // Clock with a period of 10.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Field layout of a result word, range_zero on top as bit 200.
  string field_name [11] = '{"min_a", "max_a", "min_b", "max_b", "mean_a", "mean_b",
                              "rmse", "abs_error_max", "rmse_normalized",
                              "abs_error_max_normalized", "range_zero"};
  int    field_lsb  [11] = '{0, 16, 32, 48, 64, 88, 112, 136, 152, 176, 200};
  int    field_width[11] = '{16, 16, 16, 16, 24, 24, 24, 16, 24, 24, 1};

  // Running statistics of the current run, as the block should hold them.
  longint unsigned run_count;
  longint          run_sum_a, run_sum_b;
  longint unsigned run_sq_sum, run_peak;
  longint          run_lo_a, run_hi_a, run_lo_b, run_hi_b;

  logic [200:0] stats_expected [$];
  int           fail_count = 0;
  bit           idle_enabled;
  int unsigned  cycle_count = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic longint mean_q8(longint s, longint unsigned n);
    longint unsigned mag;
    mag = (s < 0) ? -s : s;
    mag = (mag << FRAC_BITS) / n;
    return (s < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic void clear_run_stats();
    run_count = 0;
    run_sum_a = 0;
    run_sum_b = 0;
    run_sq_sum = 0;
    run_peak = 0;
  endfunction

  // Fold one accepted word into the run and, on last, queue the result.
  function automatic void fold_pair(logic [15:0] a_raw, logic [15:0] b_raw, logic last);
    longint a, b, d;
    longint unsigned ad, q, r, ms, root16, rng, nr, nl;
    logic [200:0] w;
    a = longint'(signed'(a_raw));
    b = longint'(signed'(b_raw));
    if (run_count < (64'd1 << COUNT_BITS) - 1) begin
      d = a - b;
      ad = (d < 0) ? -d : d;
      if (run_count == 0) begin
        run_lo_a = a; run_hi_a = a; run_lo_b = b; run_hi_b = b;
      end else begin
        if (a < run_lo_a) run_lo_a = a;
        if (a > run_hi_a) run_hi_a = a;
        if (b < run_lo_b) run_lo_b = b;
        if (b > run_hi_b) run_hi_b = b;
      end
      run_sum_a += a;
      run_sum_b += b;
      run_sq_sum += ad * ad;
      if (ad > run_peak) run_peak = ad;
      run_count++;
    end
    if (!last) return;
    q = run_sq_sum / run_count;
    r = run_sq_sum % run_count;
    ms = (q << 32) + ((r << 32) / run_count);
    root16 = int_sqrt(ms);
    rng = run_hi_a - run_lo_a;
    if (rng == 0) begin
      nr = 64'(NORM_MAX);
      nl = 64'(NORM_MAX);
    end else begin
      nr = root16 / rng;
      nl = (run_peak << NORM_FRAC) / rng;
      if (nr > NORM_MAX) nr = 64'(NORM_MAX);
      if (nl > NORM_MAX) nl = 64'(NORM_MAX);
    end
    w[15:0]    = run_lo_a[15:0];
    w[31:16]   = run_hi_a[15:0];
    w[47:32]   = run_lo_b[15:0];
    w[63:48]   = run_hi_b[15:0];
    w[87:64]   = 24'(mean_q8(run_sum_a, run_count));
    w[111:88]  = 24'(mean_q8(run_sum_b, run_count));
    w[135:112] = 24'(root16 >> (NORM_FRAC - FRAC_BITS));
    w[151:136] = run_peak[15:0];
    w[175:152] = nr[23:0];
    w[199:176] = nl[23:0];
    w[200]     = (rng == 0);
    stats_expected.push_back(w);
    clear_run_stats();
  endfunction

  // Send one word and wait for its handshake; valid stays high afterwards unless a random gap drops it.
  task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last);
    s_axis_tdata_i  <= {b, a};
    s_axis_tlast_i  <= last;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    fold_pair(a, b, last);
    // Random sender gaps between words.
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (stats_expected.size() != 0) @(posedge clk_i);
  endtask

  // Single-word runs, constant A and extreme differences.
  task automatic test_directed_extremes();
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'h7FFF, 16'h8000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h1234, 16'h0000, 1'b0);
    send_pair(16'h1234, 16'hFFFF, 1'b0);
    send_pair(16'h1234, 16'h5555, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'h7FFF, 16'h7FFF, 1'b1);
    // A range of one with a huge peak saturates the normalized peak.
    send_pair(16'h0000, 16'h8000, 1'b0);
    send_pair(16'h0001, 16'h7FFF, 1'b1);
    send_pair(16'hFFFF, 16'h0001, 1'b0);
    send_pair(16'hFFFE, 16'h0001, 1'b0);
    send_pair(16'hFFFD, 16'hAAAA, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'h7FFF, 16'h0000, 1'b1);
  endtask

  // Random runs of mostly short length.
  task automatic test_random_runs(int n_items);
    int sent, len;
    logic [15:0] base;
    bit flat;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      flat = ($urandom_range(0, 9) == 0);
      base = rand_sample();
      for (int i = 0; i < len; i++) begin
        send_pair(flat ? base : rand_sample(), rand_sample(), i == len - 1);
        sent++;
      end
    end
  endtask

  // The sender holds off until every result has come back.
  task automatic test_pause_until_drained();
    test_random_runs(20);
    wait_results_drained();
    test_random_runs(20);
  endtask

  // Receiver stalls in random bursts.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk_i) begin
    logic [200:0] got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tuser_o, m_axis_tdata_o};
      if (stats_expected.size() == 0) begin
        $error("unexpected result word %h", got);
        fail_count++;
      end else begin
        want = stats_expected.pop_front();
        for (int f = 0; f < 11; f++) begin
          if (((got ^ want) >> field_lsb[f]) & ((201'd1 << field_width[f]) - 1)) begin
            $error("%s: expected %h, got %h", field_name[f],
                   (want >> field_lsb[f]) & ((201'd1 << field_width[f]) - 1),
                   (got >> field_lsb[f]) & ((201'd1 << field_width[f]) - 1));
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("paired_stream_error_statistics_unit verification failed");
      $finish;
    end
  end

  initial begin
    idle_enabled = 1'b1;
    clear_run_stats();
    run_lo_a = 0; run_hi_a = 0; run_lo_b = 0; run_hi_b = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_pause_until_drained();
    test_random_runs(1000);
    idle_enabled = 1'b0;
    test_random_runs(300);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && stats_expected.size() == 0)
      $display("paired_stream_error_statistics_unit verification clean");
    else
      $display("paired_stream_error_statistics_unit verification failed");
    $finish;
  end

endmodule
